/* design/cpfv_pkg.sv */
// Shared types, constants and helper functions for the CPF check digit validator.
package cpfv_pkg;

   // Binary width of the largest in-range value (99999999999 < 2**37).
   localparam int unsigned BIN_W     = 37;
   localparam int unsigned DIGITS    = 11;
   localparam int unsigned BCD_W     = 4 * DIGITS;
   // Double-dabble steps per pipeline stage and number of such stages.
   localparam int unsigned DD_STEPS  = 8;
   localparam int unsigned DD_STAGES = (BIN_W + DD_STEPS - 1) / DD_STEPS;

   localparam logic [BIN_W-1:0] CPF_MIN = 37'd100;
   localparam logic [BIN_W-1:0] CPF_MAX = 37'd99999999999;

   // Weighted sums stay at or below 405.
   localparam int unsigned SUM_W   = 9;
   localparam int unsigned PROD_W  = 2 * SUM_W;
   localparam int unsigned Q_W     = 6;
   // floor(x / 11) == (x * 373) >> 12 for x up to 511.
   localparam logic [SUM_W-1:0] RECIP_11 = 9'd373;
   localparam logic [SUM_W-1:0] MOD_BASE = 9'd11;
   localparam logic [SUM_W-1:0] D1_WEIGHT = 9'd9;

   typedef enum logic [1:0] {
      STATUS_VALID     = 2'd0,
      STATUS_RANGE     = 2'd1,
      STATUS_ALL_EQUAL = 2'd2,
      STATUS_MISMATCH  = 2'd3
   } status_type;

   // One double-dabble step: add 3 to every digit of 5 or more, shift in b.
   function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic b);
      logic [BCD_W-1:0] adj;
      logic [3:0]       dig;
      adj = bcd;
      for (int d = 0; d < DIGITS; d++) begin
         dig = bcd[4*d +: 4];
         if (dig >= 4'd5) begin
            adj[4*d +: 4] = dig + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], b};
   endfunction

   // Check digit from a sum and its quotient by 11: remainder, with 10 folded to 0.
   function automatic logic [3:0] check_digit(input logic [SUM_W-1:0] x,
                                              input logic [Q_W-1:0]   q);
      logic [SUM_W-1:0] r;
      r = x - SUM_W'(q) * MOD_BASE;
      return (r[3:0] == 4'd10) ? 4'd0 : r[3:0];
   endfunction

endpackage

/* design/cpf_check_digit_validator.sv */
// CPF check digit validator: range check, binary-to-BCD pipeline, mod-11 check digits.
// One request per clock; busy is tied low since nothing ever stalls.
// Depth is set by the 37-step double-dabble conversion, 8 steps per stage over 5 stages,
// followed by five short stages for the weighted sums and the two mod-11 reductions.
// Reset (synchronous, active high) clears only the valid bits; no state spans requests.
module cpf_check_digit_validator (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [63:0] req_cpf_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_expected_check
);

   localparam int unsigned BIN_W  = cpfv_pkg::BIN_W;
   localparam int unsigned BCD_W  = cpfv_pkg::BCD_W;
   localparam int unsigned SUM_W  = cpfv_pkg::SUM_W;
   localparam int unsigned PROD_W = cpfv_pkg::PROD_W;
   localparam int unsigned Q_W    = cpfv_pkg::Q_W;
   localparam int unsigned NSTG   = cpfv_pkg::DD_STAGES;

   // No backpressure anywhere: a request is taken every cycle start is high.
   assign busy = 1'b0;

   logic accept;
   assign accept = start & ~busy;

   // ---------------- input stage: latch value and range flag ----------------
   logic             in_valid_ff, in_valid_in;
   logic             in_ok_ff,    in_ok_in;
   logic [BIN_W-1:0] in_bin_ff;

   // Negative values fail the upper-bits test, as in unsigned compare.
   always_comb begin
      in_valid_in = accept;
      in_ok_in    = (req_cpf_value[63:BIN_W] == '0) &&
                    (req_cpf_value[BIN_W-1:0] >= cpfv_pkg::CPF_MIN) &&
                    (req_cpf_value[BIN_W-1:0] <= cpfv_pkg::CPF_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_ok_ff  <= in_ok_in;
      in_bin_ff <= req_cpf_value[BIN_W-1:0];
   end

   // ---------------- double-dabble stages ----------------
   // Stage s converts bits MSB-first from s*DD_STEPS; the binary word rides along.
   logic             dd_valid_ff [NSTG];
   logic             dd_ok_ff    [NSTG];
   logic [BIN_W-1:0] dd_bin_ff   [NSTG];
   logic [BCD_W-1:0] dd_bcd_ff   [NSTG];

   for (genvar s = 0; s < NSTG; s++) begin : g_dd
      localparam int unsigned FIRST = s * cpfv_pkg::DD_STEPS;
      localparam int unsigned COUNT = (BIN_W - FIRST < cpfv_pkg::DD_STEPS) ?
                                      (BIN_W - FIRST) : cpfv_pkg::DD_STEPS;

      logic             src_valid;
      logic             src_ok;
      logic [BIN_W-1:0] src_bin;
      logic [BCD_W-1:0] src_bcd;
      logic [BCD_W-1:0] bcd_in;

      if (s == 0) begin : g_src_in
         assign src_valid = in_valid_ff;
         assign src_ok    = in_ok_ff;
         assign src_bin   = in_bin_ff;
         assign src_bcd   = '0;
      end else begin : g_src_dd
         assign src_valid = dd_valid_ff[s-1];
         assign src_ok    = dd_ok_ff[s-1];
         assign src_bin   = dd_bin_ff[s-1];
         assign src_bcd   = dd_bcd_ff[s-1];
      end

      always_comb begin
         bcd_in = src_bcd;
         for (int j = 0; j < COUNT; j++) begin
            bcd_in = cpfv_pkg::dd_step(bcd_in, src_bin[BIN_W-1-FIRST-j]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dd_valid_ff[s] <= 1'b0;
         end else begin
            dd_valid_ff[s] <= src_valid;
         end
         dd_ok_ff[s]  <= src_ok;
         dd_bin_ff[s] <= src_bin;
         dd_bcd_ff[s] <= bcd_in;
      end
   end

   // ---------------- stage A: weighted sums, all-equal test ----------------
   logic [3:0]       dig [cpfv_pkg::DIGITS];
   logic [SUM_W-1:0] a_s1_in, a_s2_in;
   logic             a_eq_in;

   logic             a_valid_ff, a_ok_ff, a_eq_ff;
   logic [SUM_W-1:0] a_s1_ff, a_s2_ff;
   logic [3:0]       a_hi_ff, a_lo_ff;

   // Digit i counts from the units; base digit i weighs 11-i (first) and 10-i (second).
   always_comb begin
      for (int i = 0; i < cpfv_pkg::DIGITS; i++) begin
         dig[i] = dd_bcd_ff[NSTG-1][4*i +: 4];
      end
      a_s1_in = '0;
      a_s2_in = '0;
      a_eq_in = 1'b1;
      for (int i = 2; i < cpfv_pkg::DIGITS; i++) begin
         a_s1_in = a_s1_in + SUM_W'(dig[i]) * SUM_W'(11 - i);
         a_s2_in = a_s2_in + SUM_W'(dig[i]) * SUM_W'(10 - i);
      end
      for (int i = 1; i < cpfv_pkg::DIGITS; i++) begin
         if (dig[i] != dig[0]) begin
            a_eq_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= dd_valid_ff[NSTG-1];
      end
      a_ok_ff <= dd_ok_ff[NSTG-1];
      a_eq_ff <= a_eq_in;
      a_s1_ff <= a_s1_in;
      a_s2_ff <= a_s2_in;
      a_hi_ff <= dig[1];
      a_lo_ff <= dig[0];
   end

   // ---------------- stage B: quotient of first sum by 11 ----------------
   logic [PROD_W-1:0] b_prod;
   logic              b_valid_ff, b_ok_ff, b_eq_ff;
   logic [SUM_W-1:0]  b_s1_ff, b_s2_ff;
   logic [Q_W-1:0]    b_q1_ff;
   logic [3:0]        b_hi_ff, b_lo_ff;

   assign b_prod = PROD_W'(a_s1_ff) * PROD_W'(cpfv_pkg::RECIP_11);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_ok_ff <= a_ok_ff;
      b_eq_ff <= a_eq_ff;
      b_s1_ff <= a_s1_ff;
      b_s2_ff <= a_s2_ff;
      b_q1_ff <= b_prod[PROD_W-1 -: Q_W];
      b_hi_ff <= a_hi_ff;
      b_lo_ff <= a_lo_ff;
   end

   // ---------------- stage C: first digit, fold it into second sum ----------------
   logic [3:0]       c_d1_in;
   logic             c_valid_ff, c_ok_ff, c_eq_ff;
   logic [SUM_W-1:0] c_t2_ff;
   logic [3:0]       c_d1_ff, c_hi_ff, c_lo_ff;

   assign c_d1_in = cpfv_pkg::check_digit(b_s1_ff, b_q1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_ok_ff <= b_ok_ff;
      c_eq_ff <= b_eq_ff;
      c_d1_ff <= c_d1_in;
      c_t2_ff <= b_s2_ff + SUM_W'(c_d1_in) * cpfv_pkg::D1_WEIGHT;
      c_hi_ff <= b_hi_ff;
      c_lo_ff <= b_lo_ff;
   end

   // ---------------- stage D: quotient of second sum by 11 ----------------
   logic [PROD_W-1:0] d_prod;
   logic              d_valid_ff, d_ok_ff, d_eq_ff;
   logic [SUM_W-1:0]  d_t2_ff;
   logic [Q_W-1:0]    d_q2_ff;
   logic [3:0]        d_d1_ff, d_hi_ff, d_lo_ff;

   assign d_prod = PROD_W'(c_t2_ff) * PROD_W'(cpfv_pkg::RECIP_11);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
      d_ok_ff <= c_ok_ff;
      d_eq_ff <= c_eq_ff;
      d_t2_ff <= c_t2_ff;
      d_q2_ff <= d_prod[PROD_W-1 -: Q_W];
      d_d1_ff <= c_d1_ff;
      d_hi_ff <= c_hi_ff;
      d_lo_ff <= c_lo_ff;
   end

   // ---------------- stage E: second digit, status, response register ----------------
   logic [3:0]           e_d2;
   logic [6:0]           e_expect_in;
   cpfv_pkg::status_type e_status_in;

   logic                 rsp_valid_ff;
   cpfv_pkg::status_type rsp_status_ff;
   logic [6:0]           rsp_expect_ff;

   always_comb begin
      e_d2 = cpfv_pkg::check_digit(d_t2_ff, d_q2_ff);
      if (!d_ok_ff) begin
         // Out of range reports zero check digits.
         e_status_in = cpfv_pkg::STATUS_RANGE;
         e_expect_in = '0;
      end else begin
         e_expect_in = 7'(d_d1_ff) * 7'd10 + 7'(e_d2);
         if (d_eq_ff) begin
            e_status_in = cpfv_pkg::STATUS_ALL_EQUAL;
         end else if ((d_d1_ff != d_hi_ff) || (e_d2 != d_lo_ff)) begin
            e_status_in = cpfv_pkg::STATUS_MISMATCH;
         end else begin
            e_status_in = cpfv_pkg::STATUS_VALID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d_valid_ff;
      end
      rsp_status_ff <= e_status_in;
      rsp_expect_ff <= e_expect_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_expected_check = rsp_expect_ff;

endmodule

/* sim/cpf_verdict_tracker_pkg.sv */
// Expected-result tracking and checking for the CPF check digit validator bench.
package cpf_verdict_tracker_pkg;

   typedef struct packed {
      cpfv_pkg::status_type status;
      logic [6:0]           check;
   } cpf_verdict_type;

   class cpf_verdict_tracker_type;

      cpf_verdict_type awaited[$];
      int unsigned     failures;

      function new();
         failures = 0;
      endfunction

      // Status and check digits for one candidate value.
      function cpf_verdict_type cpf_verdict(logic [63:0] value);
         cpf_verdict_type v;
         longint unsigned base;
         longint unsigned rest;
         int unsigned     s1;
         int unsigned     s2;
         int unsigned     dig;
         int unsigned     d1;
         int unsigned     d2;
         bit              same;
         v.status = cpfv_pkg::STATUS_RANGE;
         v.check  = '0;
         // negative values read as huge unsigned numbers and fail here too
         if (value < 64'd100 || value > 64'd99999999999) begin
            return v;
         end
         base = value / 100;
         s1   = 0;
         s2   = 0;
         for (int w = 9; w >= 1; w--) begin
            dig  = int'(base % 10);
            s1  += dig * w;
            s2  += dig * (w - 1);
            base = base / 10;
         end
         d1      = (s1 % 11) % 10;
         s2     += 9 * d1;
         d2      = (s2 % 11) % 10;
         v.check = 7'(d1 * 10 + d2);
         same    = 1'b1;
         rest    = value;
         for (int i = 0; i < 11; i++) begin
            if (rest % 10 != value % 10) begin
               same = 1'b0;
            end
            rest = rest / 10;
         end
         if (same) begin
            v.status = cpfv_pkg::STATUS_ALL_EQUAL;
         end else if (64'(v.check) != value % 100) begin
            v.status = cpfv_pkg::STATUS_MISMATCH;
         end else begin
            v.status = cpfv_pkg::STATUS_VALID;
         end
         return v;
      endfunction

      function void note_request(logic [63:0] value);
         awaited.push_back(cpf_verdict(value));
      endfunction

      function void check_response(logic [1:0] status, logic [6:0] check);
         cpf_verdict_type want;
         if (awaited.size() == 0) begin
            $error("unexpected response: status %0d expected_check %0d", status, check);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (check !== want.check) begin
            $error("expected_check: expected %0d, actual %0d", want.check, check);
            failures++;
         end
      endfunction

      function int unsigned pending_count();
         return awaited.size();
      endfunction

   endclass

endpackage

/* sim/cpf_check_digit_validator_tb.sv */
// Self-checking bench for the CPF check digit validator.
module cpf_check_digit_validator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // Worst case is ~1350 requests, all with the longest idle gap, plus the pipeline latency;
   // the cap sits well above that.
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned DRAIN_CYCLES    = 20;   // longer than the pipeline latency
   localparam int unsigned RESET_CYCLES    = 12;
   localparam int unsigned RANDOM_REQUESTS = 1330;
   localparam logic [63:0] CPF_TOP         = 64'd99999999999;
   localparam logic [63:0] REPDIGIT_UNIT   = 64'd11111111111;

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               start              = 1'b0;
   logic signed [63:0] req_cpf_value      = '0;
   logic               busy;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [6:0]         rsp_expected_check;

   int unsigned        cycle_count        = 0;

   cpf_verdict_tracker_pkg::cpf_verdict_tracker_type tracker = new();

   always #5 clock = ~clock;

   cpf_check_digit_validator dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cpf_value      (req_cpf_value),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_expected_check (rsp_expected_check)
   );

   // A valid CPF built from nine base digits: append the computed check digits.
   function automatic logic [63:0] valid_cpf(longint unsigned base);
      cpf_verdict_tracker_pkg::cpf_verdict_type v;
      v = tracker.cpf_verdict(base * 100);
      return base * 100 + 64'(v.check);
   endfunction

   // Same base, but last two digits deliberately off from the check digits.
   function automatic logic [63:0] broken_cpf(longint unsigned base);
      cpf_verdict_tracker_pkg::cpf_verdict_type v;
      v = tracker.cpf_verdict(base * 100);
      return base * 100 + 64'((int'(v.check) + $urandom_range(99, 1)) % 100);
   endfunction

   // Well-formed CPFs are the largest share; the rest is wrong checks, repdigits, edges and noise.
   function automatic logic [63:0] random_cpf();
      int unsigned pick;
      logic [63:0] wide;
      pick = $urandom_range(99, 0);
      wide = {$urandom, $urandom};
      if (pick < 45) begin
         return valid_cpf(longint'($urandom_range(999999999, 1)));
      end else if (pick < 65) begin
         return broken_cpf(longint'($urandom_range(999999999, 1)));
      end else if (pick < 73) begin
         return REPDIGIT_UNIT * 64'($urandom_range(9, 1));
      end else if (pick < 83) begin
         return 64'd100 + wide % (CPF_TOP - 64'd99);
      end else if (pick < 88) begin
         case ($urandom_range(3, 0))
            0: return 64'd100 + 64'($urandom_range(50, 0));
            1: return 64'($urandom_range(99, 0));
            2: return CPF_TOP - 64'($urandom_range(50, 0));
            default: return CPF_TOP + 64'($urandom_range(50, 1));
         endcase
      end
      return wide;   // full 64-bit noise, half of it negative
   endfunction

   // Idle cycles after a request: mostly none or short, now and then long.
   function automatic int unsigned idle_cycles(bit quiet);
      int unsigned roll;
      if (quiet) begin
         return 0;
      end
      roll = $urandom_range(99, 0);
      if (roll < 55) begin
         return 0;
      end else if (roll < 88) begin
         return $urandom_range(3, 1);
      end else if (roll < 98) begin
         return $urandom_range(20, 4);
      end
      return $urandom_range(100, 21);
   endfunction

   // Present one request and hold it until the block takes it.
   // With a zero gap start stays high, so the next request goes back to back.
   task automatic send_request(logic [63:0] value, int unsigned gap);
      start         <= 1'b1;
      req_cpf_value <= value;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      tracker.note_request(value);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Responses are on the ports for one cycle only; sample at the closing edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         tracker.check_response(rsp_status, rsp_expected_check);
      end
   end

   initial begin
      logic [63:0] directed[$];
      bit          quiet;
      quiet = 1'b0;

      // edges of range, sign extremes, repdigits, good and bad check digits
      directed.push_back(64'd0);
      directed.push_back(64'd99);
      directed.push_back(64'd100);
      directed.push_back(64'd101);
      directed.push_back(CPF_TOP);                   // all nines, still in range
      directed.push_back(CPF_TOP - 64'd1);
      directed.push_back(CPF_TOP + 64'd1);
      directed.push_back(64'hFFFF_FFFF_FFFF_FFFF);   // -1
      directed.push_back(64'h8000_0000_0000_0000);   // most negative
      directed.push_back(64'h7FFF_FFFF_FFFF_FFFF);   // most positive
      directed.push_back(REPDIGIT_UNIT);
      directed.push_back(REPDIGIT_UNIT * 64'd5);
      directed.push_back(valid_cpf(1));
      directed.push_back(valid_cpf(999999999));
      directed.push_back(valid_cpf(123456789));
      directed.push_back(broken_cpf(123456789));
      directed.push_back(valid_cpf(100000000));
      directed.push_back(broken_cpf(987654321));
      directed.push_back(64'd100000000);
      directed.push_back(64'h0000_0000_FFFF_FFFF);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_request(directed[i], idle_cycles(quiet));
      end

      // every 64 requests, maybe switch into a back-to-back stretch
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 64 == 0) begin
            quiet = ($urandom_range(2, 0) == 0);
         end
         send_request(random_cpf(), idle_cycles(quiet));
      end
      start <= 1'b0;

      while (tracker.pending_count() != 0) begin
         @(posedge clock);
      end
      // extra cycles catch any stray response behind the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.failures == 0 && tracker.pending_count() == 0) begin
         $display("** cpf_check_digit_validator: PASSED **");
      end else begin
         $display("** cpf_check_digit_validator: FAILED **");
      end
      $finish;
   end

   // Watchdog: a hung handshake or missing response ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** cpf_check_digit_validator: FAILED **");
      $finish;
   end

endmodule

/* sim.f */
design/cpfv_pkg.sv
design/cpf_check_digit_validator.sv
sim/cpf_verdict_tracker_pkg.sv
sim/cpf_check_digit_validator_tb.sv
